>>> rtl/core/hlf_pkg.sv
package hlf_pkg;

  // line geometry
  localparam int LINE_BYTES = 16;
  localparam int POS_W      = 4;

  // address digits: the parameter ranges from 1 to 8
  localparam int ADDRESS_DIGITS_DEF = 5;
  localparam int DIGIT_W            = 3;
  localparam int ADDR_W             = 20;
  localparam int ADDR_EXT_W         = 32;

  // character codes
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_A_LOWER = 8'h61;
  localparam logic [7:0] CHAR_TILDE   = 8'h7E;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NL      = 8'h0A;

  // what the datapath puts on the output this beat
  typedef enum logic [2:0] {
    SEL_ADDR,
    SEL_SPACE,
    SEL_HI,
    SEL_LO,
    SEL_ASCII,
    SEL_NL
  } char_sel_t;

  // controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 emit;
    char_sel_t            sel;
    logic [DIGIT_W-1:0]   digit;
    logic [POS_W-1:0]     idx;
    logic                 last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
  } status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHAR_ZERO + {4'd0, nib};
    end
    return CHAR_A_LOWER + {4'd0, nib} - 8'd10;
  endfunction

  function automatic logic [7:0] printable(input logic [7:0] c);
    if (c >= CHAR_SPACE && c <= CHAR_TILDE) begin
      return c;
    end
    return CHAR_DOT;
  endfunction

endpackage

>>> rtl/core/hlf_dpath.sv
module hlf_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hlf_pkg::cmd_t                 cmd,
  output hlf_pkg::status_t              status,
  input  logic [7:0]                    data_byte,
  input  logic [hlf_pkg::ADDR_W-1:0]    byte_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_char,
  output logic                          out_last
);

  logic [7:0]                   byte_r;
  logic [hlf_pkg::ADDR_W-1:0]   addr_r;
  logic [7:0]                   line_buf_r [hlf_pkg::LINE_BYTES];
  logic [7:0]                   char_r;
  logic                         last_r;
  logic                         valid_r;
  logic [hlf_pkg::ADDR_EXT_W-1:0] addr_ext;
  logic [7:0]                   char_nxt;

  // byte, address and ascii column captured on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r               <= data_byte;
      addr_r               <= byte_address;
      line_buf_r[cmd.idx]  <= data_byte;
    end
  end

  // character select
  assign addr_ext = {{(hlf_pkg::ADDR_EXT_W - hlf_pkg::ADDR_W){1'b0}}, addr_r};

  always_comb begin
    unique case (cmd.sel)
      hlf_pkg::SEL_ADDR:  char_nxt = hlf_pkg::hex_digit(addr_ext[{cmd.digit, 2'b00} +: 4]);
      hlf_pkg::SEL_SPACE: char_nxt = hlf_pkg::CHAR_SPACE;
      hlf_pkg::SEL_HI:    char_nxt = hlf_pkg::hex_digit(byte_r[7:4]);
      hlf_pkg::SEL_LO:    char_nxt = hlf_pkg::hex_digit(byte_r[3:0]);
      hlf_pkg::SEL_ASCII: char_nxt = hlf_pkg::printable(line_buf_r[cmd.idx]);
      hlf_pkg::SEL_NL:    char_nxt = hlf_pkg::CHAR_NL;
      default:            char_nxt = hlf_pkg::CHAR_SPACE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_r <= char_nxt;
      last_r <= cmd.last;
    end
  end

  assign status.slot_free = !valid_r || out_ready;
  assign out_valid        = valid_r;
  assign out_char         = char_r;
  assign out_last         = last_r;

endmodule

>>> rtl/core/hlf_ctrl.sv
module hlf_ctrl #(
  parameter int ADDRESS_DIGITS = hlf_pkg::ADDRESS_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hlf_pkg::status_t  status,
  output hlf_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_ASP,
    S_HI,
    S_LO,
    S_SP,
    S_XSP,
    S_ASC,
    S_NL
  } state_t;

  localparam logic [hlf_pkg::DIGIT_W-1:0] DIGIT_TOP = hlf_pkg::DIGIT_W'(ADDRESS_DIGITS - 1);
  localparam logic [hlf_pkg::POS_W-1:0]   POS_LAST  = hlf_pkg::POS_W'(hlf_pkg::LINE_BYTES - 1);

  state_t                       state_r, state_nxt;
  logic [hlf_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [hlf_pkg::DIGIT_W-1:0]  digit_r, digit_nxt;
  logic [hlf_pkg::POS_W-1:0]    aidx_r, aidx_nxt;
  logic                         load;
  logic                         emit;

  assign in_ready = (state_r == S_IDLE);
  assign load     = in_valid && in_ready;
  assign emit     = (state_r != S_IDLE) && status.slot_free;

  // command decode
  always_comb begin
    cmd       = '0;
    cmd.load  = load;
    cmd.emit  = emit;
    cmd.digit = digit_r;
    cmd.idx   = load ? pos_r : aidx_r;
    unique case (state_r)
      S_IDLE: cmd.sel = hlf_pkg::SEL_SPACE;
      S_ADDR: cmd.sel = hlf_pkg::SEL_ADDR;
      S_ASP:  cmd.sel = hlf_pkg::SEL_SPACE;
      S_HI:   cmd.sel = hlf_pkg::SEL_HI;
      S_LO: begin
        cmd.sel  = hlf_pkg::SEL_LO;
        cmd.last = !pos_r[0];
      end
      S_SP: begin
        cmd.sel  = hlf_pkg::SEL_SPACE;
        cmd.last = (pos_r != POS_LAST);
      end
      S_XSP:  cmd.sel = hlf_pkg::SEL_SPACE;
      S_ASC:  cmd.sel = hlf_pkg::SEL_ASCII;
      S_NL: begin
        cmd.sel  = hlf_pkg::SEL_NL;
        cmd.last = 1'b1;
      end
      default: cmd.sel = hlf_pkg::SEL_SPACE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    digit_nxt = digit_r;
    aidx_nxt  = aidx_r;
    if (load) begin
      state_nxt = (pos_r == '0) ? S_ADDR : S_HI;
      digit_nxt = DIGIT_TOP;
    end else if (emit) begin
      unique case (state_r)
        S_ADDR: begin
          if (digit_r == '0) begin
            state_nxt = S_ASP;
          end else begin
            digit_nxt = digit_r - 1'b1;
          end
        end
        S_ASP: state_nxt = S_HI;
        S_HI:  state_nxt = S_LO;
        S_LO: begin
          if (pos_r[0]) begin
            state_nxt = S_SP;
          end else begin
            state_nxt = S_IDLE;
            pos_nxt   = pos_r + 1'b1;
          end
        end
        S_SP: begin
          if (pos_r == POS_LAST) begin
            state_nxt = S_XSP;
          end else begin
            state_nxt = S_IDLE;
            pos_nxt   = pos_r + 1'b1;
          end
        end
        S_XSP: begin
          state_nxt = S_ASC;
          aidx_nxt  = '0;
        end
        S_ASC: begin
          if (aidx_r == POS_LAST) begin
            state_nxt = S_NL;
          end else begin
            aidx_nxt = aidx_r + 1'b1;
          end
        end
        S_NL: begin
          state_nxt = S_IDLE;
          pos_nxt   = pos_r + 1'b1;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      digit_r <= '0;
      aidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      digit_r <= digit_nxt;
      aidx_r  <= aidx_nxt;
    end
  end

  // checks
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after the last beat");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (pos_r == hlf_pkg::POS_W'($past(pos_r) + 1'b1)))
    else $error("line position did not advance after the last beat");

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && cmd.last) |=> $stable(pos_r))
    else $error("line position moved mid item");

  a_addr_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDR || state_r == S_ASP) |-> (pos_r == '0))
    else $error("address printed away from line start");

  a_tail_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XSP || state_r == S_ASC || state_r == S_NL) |-> (pos_r == POS_LAST))
    else $error("ascii column printed before the sixteenth byte");

endmodule

>>> rtl/core/hexdump_line_formatter.sv
// first character: an accept beat loads the controller state register, and the emit from that
//   state loads the output register that drives out_tdata; a byte causes n characters (2 to 21),
//   one character per cycle through the output register while out_tready is high; the next
//   byte is not accepted until its last character has entered the output register
// reset (rst_n, synchronous, active low) clears the controller, the line position and
//   the output valid; the ascii line buffer is not cleared
module hexdump_line_formatter #(
  parameter int ADDRESS_DIGITS = hlf_pkg::ADDRESS_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_byte [7:0], byte_address [27:8], zero [31:28]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // character [7:0]
  output logic        out_tlast
);

  hlf_pkg::cmd_t    cmd;
  hlf_pkg::status_t status;

  // sequencer
  hlf_ctrl #(
    .ADDRESS_DIGITS (ADDRESS_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // byte store, character select and output register
  hlf_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .data_byte    (in_tdata[7:0]),
    .byte_address (in_tdata[27:8]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_char     (out_tdata),
    .out_last     (out_tlast)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int ADDR_DIGITS  = hlf_pkg::ADDRESS_DIGITS_DEF;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_TICKS = 40;
  localparam int PHASE_BYTES  = 30;

  // one character of dump text and its end-of-byte flag
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dump_char_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // data_byte [7:0], byte_address [27:8], zero [31:28]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // character [7:0]
  logic        out_tlast;

  // predictor state
  logic [hlf_pkg::POS_W-1:0] line_pos;
  logic [7:0]                line_bytes [hlf_pkg::LINE_BYTES];
  dump_char_t                dump_text_q [$];

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  dump_char_t want_char;

  hexdump_line_formatter #(
    .ADDRESS_DIGITS(ADDR_DIGITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return hlf_pkg::CHAR_ZERO + n;
    end
    return hlf_pkg::CHAR_A_LOWER + (n - 4'd10);
  endfunction

  function automatic logic [7:0] shown_char(input logic [7:0] c);
    if (c >= hlf_pkg::CHAR_SPACE && c <= hlf_pkg::CHAR_TILDE) begin
      return c;
    end
    return hlf_pkg::CHAR_DOT;
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic is_last);
    dump_char_t d;
    d.ch   = c;
    d.last = is_last;
    dump_text_q.push_back(d);
  endfunction

  // dump text caused by one accepted byte
  function automatic void predict_dump_text(input logic [7:0] b, input logic [19:0] a);
    logic [31:0] addr_ext;
    addr_ext = {12'd0, a};
    if (line_pos == '0) begin
      for (int i = 0; i < ADDR_DIGITS; i++) begin
        push_char(nibble_char(4'(addr_ext >> ((ADDR_DIGITS - 1 - i) * 4))), 1'b0);
      end
      push_char(hlf_pkg::CHAR_SPACE, 1'b0);
    end
    line_bytes[line_pos] = b;
    push_char(nibble_char(b[7:4]), 1'b0);
    push_char(nibble_char(b[3:0]), !line_pos[0]);
    if (line_pos[0]) begin
      push_char(hlf_pkg::CHAR_SPACE,
                line_pos != hlf_pkg::POS_W'(hlf_pkg::LINE_BYTES - 1));
    end
    if (line_pos == hlf_pkg::POS_W'(hlf_pkg::LINE_BYTES - 1)) begin
      push_char(hlf_pkg::CHAR_SPACE, 1'b0);
      for (int i = 0; i < hlf_pkg::LINE_BYTES; i++) begin
        push_char(shown_char(line_bytes[i]), 1'b0);
      end
      push_char(hlf_pkg::CHAR_NL, 1'b1);
    end
    line_pos = line_pos + 1'b1;
  endfunction

  // send one byte; called and returning at a falling edge, valid left high
  task automatic send_byte(input logic [7:0] b, input logic [19:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, a, b};
    do begin
      @(posedge clk);
    end while (!in_tready);
    predict_dump_text(b, a);
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [7] = '{8'h00, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'h80, 8'hff};
    case ($urandom_range(3))
      0:       return edges[$urandom_range(6)];
      1:       return 8'($urandom_range(8'h20, 8'h7e));
      default: return 8'($urandom());
    endcase
  endfunction

  // one full line with edge bytes at the top address, then part of a line at zero;
  // addresses of non-leading bytes are random and must be ignored
  task automatic test_directed_line();
    logic [7:0] first_line [16] = '{8'h00, 8'hff, 8'h09, 8'h0a, 8'h1f, 8'h20, 8'h7e, 8'h7f,
                                    8'h80, 8'h30, 8'h39, 8'h41, 8'h5a, 8'h61, 8'h7a, 8'h2e};
    logic [7:0] next_line [9]  = '{8'ha5, 8'h5a, 8'hc3, 8'h3c, 8'h0f, 8'hf0, 8'h12, 8'h34,
                                    8'h56};
    set_idling(0, 0);
    for (int i = 0; i < 16; i++) begin
      send_byte(first_line[i], (i == 0) ? 20'hfffff : 20'($urandom()));
    end
    for (int i = 0; i < 9; i++) begin
      send_byte(next_line[i], (i == 0) ? 20'h00000 : 20'($urandom()));
    end
  endtask

  task automatic test_random_mix(input int send_pct, input int stall_pct);
    set_idling(send_pct, stall_pct);
    for (int i = 0; i < PHASE_BYTES; i++) begin
      send_byte(pick_byte(), 20'($urandom()));
    end
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_output_hold();
    set_idling(0, 0);
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_byte(pick_byte(), 20'($urandom()));
    end
  endtask

  // receiver ready, with random stalls and one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each output beat against the oldest expected character
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (dump_text_q.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want_char = dump_text_q.pop_front();
        if (out_tdata !== want_char.ch) begin
          $display("%0t: character mismatch, expected %h, actual %h",
                   $time, want_char.ch, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want_char.last) begin
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want_char.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d characters outstanding", $time, dump_text_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    line_pos       = '0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_line();
    test_random_mix(0, 0);
    test_random_mix(70, 0);
    test_random_mix(0, 70);
    test_random_mix(12, 12);
    test_output_hold();

    // drain and let any stray characters show up
    in_tvalid <= 1'b0;
    set_idling(0, 0);
    while (dump_text_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/hlf_pkg.sv
rtl/core/hlf_dpath.sv
rtl/core/hlf_ctrl.sv
rtl/core/hexdump_line_formatter.sv
tb/testbench.sv
